// File: src/pfsa_pkg.sv
// Package for the page frame stack allocator.
// Holds field widths, command codes and the controller's state and result types.
// No dependencies; every other file refers to it by scoped names.
package pfsa_pkg;

    // Fixed widths of the item fields.
    localparam int FRAME_W   = 11;
    localparam int CMD_W     = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Command codes carried in the input item's tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_REL_WHOLE  = 2'd0,
        CMD_TAKE_WHOLE = 2'd1,
        CMD_REL_HALF   = 2'd2,
        CMD_TAKE_HALF  = 2'd3
    } cmd_t;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // How the result of the item in flight is formed once the stack read returns.
    typedef enum logic [2:0] {
        RES_OK    = 3'd0,
        RES_FAIL  = 3'd1,
        RES_WHOLE = 3'd2,
        RES_HALF  = 3'd3,
        RES_SPLIT = 3'd4
    } res_kind_t;

endpackage

// File: src/page_frame_stack_allocator.sv
// Page frame stack allocator: two LIFO free lists of whole and half frames.
// An accepted item moves the controller to ST_EXEC, where its result is loaded into the
// output register once that register is free; no new item is taken until then, since a pop
// must wait for the registered read of the stack memories. Reset clears the stack counts
// and the handshake state; the stack memories are not cleared, since only entries below
// a count are ever read. Depends on pfsa_pkg.
module page_frame_stack_allocator #(
    parameter int NUM_FRAMES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Command items.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pfsa_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [10:0] frame_number, rest zero
    input  logic [pfsa_pkg::CMD_W-1:0]    s_axis_tuser,  // [1:0] command
    // Result items.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pfsa_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [10:0] result_frame, rest zero
    output logic [0:0]                    m_axis_tuser   // [0] failed
);

    // Widths derived from the number of frames. Stored values are also bounded by the
    // 11-bit frame field, so entries never need more than FRAME_W bits.
    localparam int FW      = pfsa_pkg::FRAME_W;
    localparam int WHOLE_W = (NUM_FRAMES >= 2048) ? FW : $clog2(NUM_FRAMES);
    localparam int HALF_W  = (2 * NUM_FRAMES >= 2048) ? FW : $clog2(2 * NUM_FRAMES);
    localparam int WA_W    = $clog2(NUM_FRAMES);
    localparam int HA_W    = $clog2(2 * NUM_FRAMES);
    localparam int WC_W    = $clog2(NUM_FRAMES + 1);
    localparam int HC_W    = $clog2(2 * NUM_FRAMES + 1);

    // The two free stacks live in synchronous memories with a registered read port.
    logic [WHOLE_W-1:0] whole_mem [NUM_FRAMES];
    logic [HALF_W-1:0]  half_mem  [2 * NUM_FRAMES];

    pfsa_pkg::state_t    state_reg, state_next;
    pfsa_pkg::res_kind_t kind_reg, kind_next;
    logic [WC_W-1:0]     whole_count_reg, whole_count_next;
    logic [HC_W-1:0]     half_count_reg, half_count_next;
    logic [WHOLE_W-1:0]  whole_rd_reg;
    logic [HALF_W-1:0]   half_rd_reg;
    logic                out_valid_reg, out_valid_next;
    logic [FW-1:0]       out_frame_reg, out_frame_next;
    logic                out_fail_reg, out_fail_next;

    logic                accept;
    logic                out_load;
    pfsa_pkg::cmd_t      cmd;
    logic [FW-1:0]       frame_in;
    logic                whole_full, half_full;
    logic                whole_range_bad, half_range_bad;
    logic [WC_W-1:0]     whole_cm1;
    logic [HC_W-1:0]     half_cm1;
    logic                whole_we, whole_re;
    logic                half_we, half_re;
    logic [HA_W-1:0]     half_waddr;
    logic [HALF_W-1:0]   half_wdata;
    logic [FW-1:0]       p_ext;
    logic [FW-1:0]       split_even;
    logic [FW-1:0]       split_odd;

    assign cmd      = pfsa_pkg::cmd_t'(s_axis_tuser);
    assign frame_in = s_axis_tdata[FW-1:0];

    // A new command is taken only in ST_IDLE, when no earlier command is in flight. The output
    // register can still hold an untaken result while the next command is accepted.
    assign s_axis_tready = (state_reg == pfsa_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == pfsa_pkg::ST_EXEC) && (!out_valid_reg || m_axis_tready);

    assign whole_full      = (whole_count_reg == WC_W'(NUM_FRAMES));
    assign half_full       = (half_count_reg == HC_W'(2 * NUM_FRAMES));
    assign whole_range_bad = (32'(frame_in) >= NUM_FRAMES);
    assign half_range_bad  = (32'(frame_in) >= 2 * NUM_FRAMES);
    assign whole_cm1       = whole_count_reg - WC_W'(1);
    assign half_cm1        = half_count_reg - HC_W'(1);

    // Split of frame p: half 2p goes out, half 2p+1 goes onto the half stack.
    // Both are masked to the 11-bit frame field.
    assign p_ext      = FW'(whole_rd_reg);
    assign split_even = {p_ext[FW-2:0], 1'b0};
    assign split_odd  = {p_ext[FW-2:0], 1'b1};

    // Decode of the accepted command. Counts and release pushes are settled in the accept cycle;
    // pops start their memory read here and finish in ST_EXEC, where a split pushes its upper half.
    always_comb
    begin
        kind_next        = kind_reg;
        whole_count_next = whole_count_reg;
        half_count_next  = half_count_reg;
        whole_we         = 1'b0;
        whole_re         = 1'b0;
        half_re          = 1'b0;
        if (accept)
        begin
            unique case (cmd)
                pfsa_pkg::CMD_REL_WHOLE:
                begin
                    if (whole_full || whole_range_bad)
                    begin
                        kind_next = pfsa_pkg::RES_FAIL;
                    end
                    else
                    begin
                        kind_next        = pfsa_pkg::RES_OK;
                        whole_we         = 1'b1;
                        whole_count_next = whole_count_reg + WC_W'(1);
                    end
                end
                pfsa_pkg::CMD_TAKE_WHOLE:
                begin
                    if (whole_count_reg == '0)
                    begin
                        kind_next = pfsa_pkg::RES_FAIL;
                    end
                    else
                    begin
                        kind_next        = pfsa_pkg::RES_WHOLE;
                        whole_re         = 1'b1;
                        whole_count_next = whole_cm1;
                    end
                end
                pfsa_pkg::CMD_REL_HALF:
                begin
                    if (half_full || half_range_bad)
                    begin
                        kind_next = pfsa_pkg::RES_FAIL;
                    end
                    else
                    begin
                        kind_next       = pfsa_pkg::RES_OK;
                        half_count_next = half_count_reg + HC_W'(1);
                    end
                end
                pfsa_pkg::CMD_TAKE_HALF:
                begin
                    if (half_count_reg != '0)
                    begin
                        kind_next       = pfsa_pkg::RES_HALF;
                        half_re         = 1'b1;
                        half_count_next = half_cm1;
                    end
                    else if (whole_count_reg != '0)
                    begin
                        // The half stack is empty, so after the split it holds one entry.
                        kind_next        = pfsa_pkg::RES_SPLIT;
                        whole_re         = 1'b1;
                        whole_count_next = whole_cm1;
                        half_count_next  = HC_W'(1);
                    end
                    else
                    begin
                        kind_next = pfsa_pkg::RES_FAIL;
                    end
                end
                default:
                begin
                    kind_next = pfsa_pkg::RES_FAIL;
                end
            endcase
        end
    end

    // The half stack has one write port, shared by a release in the accept cycle
    // and the split push in ST_EXEC. The two never fall in the same cycle.
    always_comb
    begin
        half_we    = 1'b0;
        half_waddr = half_count_reg[HA_W-1:0];
        half_wdata = frame_in[HALF_W-1:0];
        if (accept && (cmd == pfsa_pkg::CMD_REL_HALF) && !half_full && !half_range_bad)
        begin
            half_we = 1'b1;
        end
        else if ((state_reg == pfsa_pkg::ST_EXEC) && (kind_reg == pfsa_pkg::RES_SPLIT))
        begin
            half_we    = 1'b1;
            half_waddr = '0;
            half_wdata = split_odd[HALF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (whole_we)
        begin
            whole_mem[whole_count_reg[WA_W-1:0]] <= frame_in[WHOLE_W-1:0];
        end
        if (whole_re)
        begin
            whole_rd_reg <= whole_mem[whole_cm1[WA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (half_we)
        begin
            half_mem[half_waddr] <= half_wdata;
        end
        if (half_re)
        begin
            half_rd_reg <= half_mem[half_cm1[HA_W-1:0]];
        end
    end

    // Controller and output register.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_frame_next = out_frame_reg;
        out_fail_next  = out_fail_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            pfsa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pfsa_pkg::ST_EXEC;
                end
            end
            pfsa_pkg::ST_EXEC:
            begin
                if (out_load)
                begin
                    state_next     = pfsa_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    out_fail_next  = (kind_reg == pfsa_pkg::RES_FAIL);
                    unique case (kind_reg)
                        pfsa_pkg::RES_WHOLE: out_frame_next = p_ext;
                        pfsa_pkg::RES_HALF:  out_frame_next = FW'(half_rd_reg);
                        pfsa_pkg::RES_SPLIT: out_frame_next = split_even;
                        default:             out_frame_next = '0;
                    endcase
                end
            end
            default:
            begin
                state_next = pfsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pfsa_pkg::ST_IDLE;
            kind_reg        <= pfsa_pkg::RES_OK;
            whole_count_reg <= '0;
            half_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            whole_count_reg <= whole_count_next;
            half_count_reg  <= half_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_frame_reg <= out_frame_next;
        out_fail_reg  <= out_fail_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(pfsa_pkg::M_TDATA_W - FW){1'b0}}, out_frame_reg};
    assign m_axis_tuser  = out_fail_reg;

endmodule

// File: src/pfsa_checker.sv
// Port-level checker for the page frame stack allocator, with its bind statement.
// Depends on pfsa_pkg and on the top level page_frame_stack_allocator.
module pfsa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pfsa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                     m_axis_tuser
);

    // A stalled result item holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // A failed item never hands out a frame.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("failed result carries a nonzero frame");

    // After an accepted command the block takes no command in the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while the previous one is in flight");

    // An accepted command, taken while the output register is empty or being emptied, moves
    // through ST_EXEC into the output register, so that register cannot stay empty.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready)
        |=> ##1 m_axis_tvalid)
        else $error("accepted command produced no result");

endmodule

bind page_frame_stack_allocator pfsa_checker u_pfsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_frame_stack_allocator.
// It drives command items, predicts every result with its own model of both free stacks,
// and checks the results in order. Depends on pfsa_pkg and the allocator RTL.
module testbench;

    localparam int FRAME_W   = pfsa_pkg::FRAME_W;
    localparam int CMD_W     = pfsa_pkg::CMD_W;
    localparam int S_TDATA_W = pfsa_pkg::S_TDATA_W;
    localparam int M_TDATA_W = pfsa_pkg::M_TDATA_W;

    localparam int NUM_FRAMES     = 1024;
    localparam int HOLD_CYCLES    = 300;   // long receiver stall that backs up the block
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES   = 8;     // margin after the last result has come back

    // Command mixes for the random part. A growing mix fills the stacks, a draining mix
    // empties the half stack often enough that takes have to split whole frames.
    typedef enum int {
        MIX_GROW,
        MIX_EVEN,
        MIX_DRAIN
    } mix_t;

    // One result item as the block should present it.
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               failed;
    } grant_t;

    // One row of the directed stimulus. Where known is set, the expected result is typed
    // in; otherwise it comes from the predictor.
    typedef struct packed {
        pfsa_pkg::cmd_t     cmd;
        logic [FRAME_W-1:0] num;
        logic               known;
        logic [FRAME_W-1:0] exp_frame;
        logic               exp_fail;
    } dir_row_t;

    localparam int DIR_ROWS = 25;

    // The run starts with both stacks empty, so the first rows exercise failed takes,
    // out-of-range releases, a split and the LIFO order of the half stack.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{pfsa_pkg::CMD_TAKE_WHOLE, 11'd0,    1'b1, 11'd0,    1'b1},  // empty whole stack
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd2047, 1'b1, 11'd0,    1'b1},  // both stacks empty
        '{pfsa_pkg::CMD_REL_WHOLE,  11'd1024, 1'b1, 11'd0,    1'b1},  // first frame past end
        '{pfsa_pkg::CMD_REL_WHOLE,  11'd2047, 1'b1, 11'd0,    1'b1},  // largest field value
        '{pfsa_pkg::CMD_REL_WHOLE,  11'd1023, 1'b1, 11'd0,    1'b0},  // last valid frame
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b1, 11'd2046, 1'b0},  // split of frame 1023
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b1, 11'd2047, 1'b0},  // its upper half
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b1, 11'd0,    1'b1},  // empty again
        '{pfsa_pkg::CMD_REL_WHOLE,  11'd0,    1'b1, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd2047, 1'b1, 11'd0,    1'b0},  // split of frame 0
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b1, 11'd1,    1'b0},
        '{pfsa_pkg::CMD_REL_HALF,   11'd2047, 1'b1, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_REL_HALF,   11'd0,    1'b1, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b1, 11'd0,    1'b0},  // last in, first out
        '{pfsa_pkg::CMD_REL_WHOLE,  11'd512,  1'b0, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_REL_WHOLE,  11'd1023, 1'b0, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_TAKE_WHOLE, 11'd1365, 1'b0, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_REL_HALF,   11'd1365, 1'b0, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_REL_HALF,   11'd682,  1'b0, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b0, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b0, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b0, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b0, 11'd0,    1'b0},
        '{pfsa_pkg::CMD_TAKE_WHOLE, 11'd0,    1'b1, 11'd0,    1'b1},  // whole stack empty
        '{pfsa_pkg::CMD_TAKE_HALF,  11'd0,    1'b0, 11'd0,    1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // [10:0] frame_number, rest zero
    logic [CMD_W-1:0]      s_axis_tuser;   // [1:0] command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // [10:0] result_frame, rest zero
    logic [0:0]            m_axis_tuser;   // [0] failed

    // Predictor state: its own copy of both free stacks.
    logic [FRAME_W-1:0] free_whole [NUM_FRAMES];
    logic [FRAME_W-1:0] free_half  [2*NUM_FRAMES];
    int                 whole_depth = 0;
    int                 half_depth  = 0;

    // Results still owed by the block, oldest first.
    grant_t expected_grants [$];

    // Knobs shared between the stimulus and the receiver.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_requests = 0;

    // Run statistics.
    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int fails_seen    = 0;
    int split_count   = 0;
    int whole_peak    = 0;
    int half_peak     = 0;
    int quiet_cycles  = 0;

    page_frame_stack_allocator #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predict the result of one command and update the predictor's stacks. A release to a
    // full stack or of an index past the end is dropped and flagged. A half take with an
    // empty half stack splits the top whole frame: the upper half is kept, the lower one
    // handed out.
    function automatic void predict_allocation(input pfsa_pkg::cmd_t c,
                                               input logic [FRAME_W-1:0] n,
                                               output grant_t g);
        logic [FRAME_W-1:0] p;
        g = '0;
        case (c)
            pfsa_pkg::CMD_REL_WHOLE:
            begin
                if (whole_depth >= NUM_FRAMES || n >= NUM_FRAMES)
                    g.failed = 1'b1;
                else
                begin
                    free_whole[whole_depth] = n;
                    whole_depth++;
                end
            end
            pfsa_pkg::CMD_TAKE_WHOLE:
            begin
                if (whole_depth == 0)
                    g.failed = 1'b1;
                else
                begin
                    whole_depth--;
                    g.frame = free_whole[whole_depth];
                end
            end
            pfsa_pkg::CMD_REL_HALF:
            begin
                if (half_depth >= 2*NUM_FRAMES || n >= 2*NUM_FRAMES)
                    g.failed = 1'b1;
                else
                begin
                    free_half[half_depth] = n;
                    half_depth++;
                end
            end
            default:
            begin
                if (half_depth != 0)
                begin
                    half_depth--;
                    g.frame = free_half[half_depth];
                end
                else if (whole_depth != 0)
                begin
                    whole_depth--;
                    p = free_whole[whole_depth];
                    free_half[0] = {p[FRAME_W-2:0], 1'b1};
                    half_depth = 1;
                    g.frame = {p[FRAME_W-2:0], 1'b0};
                    split_count++;
                end
                else
                    g.failed = 1'b1;
            end
        endcase
        if (whole_depth > whole_peak)
            whole_peak = whole_depth;
        if (half_depth > half_peak)
            half_peak = half_depth;
    endfunction

    // Offer one command item, starting at a falling edge, with random gaps in front of it.
    // On acceptance the expected result is queued; the task returns at the next falling
    // edge without touching tvalid there, so a following item keeps it high.
    task automatic issue_command(input pfsa_pkg::cmd_t c, input logic [FRAME_W-1:0] n,
                                 input logic known, input logic [FRAME_W-1:0] exp_frame,
                                 input logic exp_fail);
        grant_t g;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-FRAME_W){1'b0}}, n};
        s_axis_tuser  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_allocation(c, n, g);
        if (known)
        begin
            g.frame  = exp_frame;
            g.failed = exp_fail;
        end
        expected_grants.push_back(g);
        items_sent++;
        @(negedge clk);
    endtask

    // Sender pause: stop offering and wait until every result owed has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Pick one random command. Whole releases stay mostly in range, with some past the
    // end; the frame number is random on takes as well, since the block must ignore it.
    task automatic pick_command(input mix_t mix, output pfsa_pkg::cmd_t c,
                                output logic [FRAME_W-1:0] n);
        int roll;
        int w_rel_whole;
        int w_take_whole;
        int w_rel_half;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
            begin
                w_rel_whole = 35; w_take_whole = 15; w_rel_half = 30;
            end
            MIX_DRAIN:
            begin
                w_rel_whole = 10; w_take_whole = 35; w_rel_half = 10;
            end
            default:
            begin
                w_rel_whole = 25; w_take_whole = 25; w_rel_half = 25;
            end
        endcase
        if (roll < w_rel_whole)
            c = pfsa_pkg::CMD_REL_WHOLE;
        else if (roll < w_rel_whole + w_take_whole)
            c = pfsa_pkg::CMD_TAKE_WHOLE;
        else if (roll < w_rel_whole + w_take_whole + w_rel_half)
            c = pfsa_pkg::CMD_REL_HALF;
        else
            c = pfsa_pkg::CMD_TAKE_HALF;
        if (c == pfsa_pkg::CMD_REL_WHOLE && $urandom_range(0, 99) < 88)
            n = FRAME_W'($urandom_range(0, NUM_FRAMES-1));
        else
            n = FRAME_W'($urandom_range(0, 2047));
    endtask

    task automatic run_random(input int count);
        mix_t               mix;
        pfsa_pkg::cmd_t     c;
        logic [FRAME_W-1:0] n;
        mix = MIX_EVEN;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                mix = mix_t'($urandom_range(0, 2));
            pick_command(mix, c, n);
            issue_command(c, n, 1'b0, '0, 1'b0);
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    // The hold-off is counted here so that the sender can keep offering items meanwhile.
    initial
    begin : sink
        int hold_left;
        int holds_taken;
        hold_left     = 0;
        holds_taken   = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_taken != hold_requests)
            begin
                hold_left   = HOLD_CYCLES;
                holds_taken = hold_requests;
            end
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (m_axis_tuser[0])
                fails_seen++;
            if (expected_grants.size() == 0)
            begin
                $error("result with nothing pending: result_frame %0d failed %0d",
                       m_axis_tdata[FRAME_W-1:0], m_axis_tuser[0]);
                errors++;
            end
            else
            begin
                g = expected_grants.pop_front();
                if (m_axis_tdata[FRAME_W-1:0] !== g.frame)
                begin
                    $error("result_frame: expected %0d, got %0d", g.frame,
                           m_axis_tdata[FRAME_W-1:0]);
                    errors++;
                end
                if (m_axis_tuser[0] !== g.failed)
                begin
                    $error("failed: expected %0d, got %0d", g.failed, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata[M_TDATA_W-1:FRAME_W] !== '0)
                begin
                    $error("tdata padding: expected 0, got %0h",
                           m_axis_tdata[M_TDATA_W-1:FRAME_W]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake means the block has hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = pfsa_pkg::CMD_REL_WHOLE;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Phase one: sender rarely idles, receiver often does.
        src_idle_pct  = 9;
        sink_idle_pct = 47;
        for (int i = 0; i < DIR_ROWS; i++)
            issue_command(dir_rows[i].cmd, dir_rows[i].num, dir_rows[i].known,
                          dir_rows[i].exp_frame, dir_rows[i].exp_fail);
        run_random(120);
        // Long receiver stall while items keep coming, so the input backs up.
        hold_requests++;
        run_random(200);
        wait_for_results();

        // Phase two: the other way round.
        src_idle_pct  = 47;
        sink_idle_pct = 9;
        run_random(330);
        wait_for_results();

        // Phase three: no idling on either side.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(330);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands and checked %0d results, %0d of them flagged as failed.",
                 items_sent, results_seen, fails_seen);
        $display("Saw %0d whole-frame splits; stack peaks %0d/%0d whole and %0d/%0d half.",
                 split_count, whole_peak, NUM_FRAMES, half_peak, 2*NUM_FRAMES);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
